// ----- hdl/hdj_pkg.sv -----
package hdj_pkg;

	// Default plate edge length in cells.
	localparam int GRID_SIZE_DEF = 64;

	localparam int CELL_W     = 24;
	localparam int GAIN_W     = 15;
	localparam int SWEEP_W    = 16;
	localparam int OP_W       = 2;
	localparam int COORD_W    = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int FRAC_W     = 16;

	// Neighbor sum minus four times the center needs two extra bits and a sign.
	localparam int ACC_W  = CELL_W + 3;
	localparam int PROD_W = ACC_W + GAIN_W + 1;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SWEEPS = 2'd2;

	localparam logic [GAIN_W-1:0]  GAIN_RST   = 15'd16384;
	localparam logic [CELL_W-1:0]  HOT_RST    = 24'd6553600;
	localparam logic [SWEEP_W-1:0] SWEEPS_RST = 16'd5000;

	typedef struct packed {
		logic ld_center;
		logic add_nb;
		logic mul;
	} alu_ctrl_t;

endpackage

// ----- hdl/hdj_cmd_if.sv -----
interface hdj_cmd_if;
	import hdj_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [COORD_W-1:0] row;
	logic [COORD_W-1:0] col;
	logic [CELL_W-1:0] cell_in;

	modport source (output valid, operation, row, col, cell_in, input ready);
	modport sink (input valid, operation, row, col, cell_in, output ready);
endinterface

// ----- hdl/hdj_rsp_if.sv -----
interface hdj_rsp_if;
	import hdj_pkg::*;

	logic              valid;
	logic              ready;
	logic [CELL_W-1:0] cell_out;
	logic              run_done;

	modport source (output valid, cell_out, run_done, input ready);
	modport sink (input valid, cell_out, run_done, output ready);
endinterface

// ----- hdl/hdj_ram.sv -----
module hdj_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- hdl/hdj_cell_alu.sv -----
module hdj_cell_alu (
	input  logic                      clk,
	input  hdj_pkg::alu_ctrl_t        ctrl,
	input  logic [hdj_pkg::CELL_W-1:0] rd_data,
	input  logic [hdj_pkg::GAIN_W-1:0] gain,
	output logic [hdj_pkg::CELL_W-1:0] result
);
	import hdj_pkg::*;

	logic        [CELL_W-1:0] center_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  base;
	logic signed [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0]  acc_sum;
	logic signed [ACC_W-1:0]  delta;
	logic signed [ACC_W:0]    sum_c;

	// One adder serves the whole neighbor sum: the first term is -4*center.
	always_comb begin
		if (ctrl.ld_center) begin
			base   = '0;
			addend = -$signed({1'b0, rd_data, 2'b00});
		end else begin
			base   = acc_q;
			addend = $signed({3'b000, rd_data});
		end
		acc_sum = base + addend;
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_center) begin
			center_q <= rd_data;
		end
		if (ctrl.ld_center || ctrl.add_nb) begin
			acc_q <= acc_sum;
		end
		if (ctrl.mul) begin
			prod_q <= acc_q * $signed({1'b0, gain});
		end
	end

	// Arithmetic shift floors towards minus infinity, then clamp to the cell range.
	always_comb begin
		delta = prod_q[PROD_W-1:FRAC_W];
		sum_c = $signed({4'b0000, center_q}) + $signed({delta[ACC_W-1], delta});
		if (sum_c[ACC_W]) begin
			result = '0;
		end else if (|sum_c[ACC_W-1:CELL_W]) begin
			result = '1;
		end else begin
			result = sum_c[CELL_W-1:0];
		end
	end
endmodule

// ----- hdl/heat_diffusion_jacobi_stencil.sv -----
// Channel   Dir   Payload                            Handshake
// cmd       in    operation, row, col, cell_in       valid/ready, taken when both high
// rsp       out   cell_out, run_done                 valid/ready, taken when both high
// cfg       in    cfg_index, cfg_data                cfg_we, no back-pressure
//
// A write item, or an item with the unused operation code, is answered from idle.
// A read item goes through ST_READ because the grid memory has a registered read port.
// A run item forces the edges over all N*N cells, then per sweep writes each edge cell
// directly and takes each interior cell through the steps STP_CENTER to STP_WRITE of
// the one shared stencil unit that reads five cells through a single memory read port;
// N is GRID_SIZE. After reset both grids are cleared, all N*N cells, 4096 by default.
// Each item gives one response; a new item is taken only when the response slot is
// free or being emptied in the same cycle, so a stalled rsp channel stalls cmd.
module heat_diffusion_jacobi_stencil #(
	parameter int GRID_SIZE = hdj_pkg::GRID_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hdj_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hdj_pkg::CFG_DATA_W-1:0] cfg_data,
	hdj_cmd_if.sink                       cmd,
	hdj_rsp_if.source                     rsp
);
	import hdj_pkg::*;

	localparam int CELLS = GRID_SIZE * GRID_SIZE;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(GRID_SIZE);

	localparam logic [CW-1:0] LAST_IDX  = CW'(GRID_SIZE - 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
	localparam logic [AW-1:0] ROW_STEP  = AW'(GRID_SIZE);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_FORCE = 3'd3;
	localparam logic [2:0] ST_SWEEP = 3'd4;

	// Steps of one interior cell in the stencil unit.
	localparam logic [2:0] STP_CENTER = 3'd0;
	localparam logic [2:0] STP_NORTH  = 3'd1;
	localparam logic [2:0] STP_SOUTH  = 3'd2;
	localparam logic [2:0] STP_EAST   = 3'd3;
	localparam logic [2:0] STP_WEST   = 3'd4;
	localparam logic [2:0] STP_LAST   = 3'd5;
	localparam logic [2:0] STP_MUL    = 3'd6;
	localparam logic [2:0] STP_WRITE  = 3'd7;

	logic [2:0]         state_q;
	logic [2:0]         step_q;
	logic [AW-1:0]      addr_q;
	logic [CW-1:0]      row_q;
	logic [CW-1:0]      col_q;
	logic [SWEEP_W-1:0] sweep_left_q;
	logic               cur_b_q;
	logic               rd_inside_q;

	logic [GAIN_W-1:0]  gain_q;
	logic [CELL_W-1:0]  hot_q;
	logic [SWEEP_W-1:0] sweeps_q;

	logic               rsp_valid_q;
	logic [CELL_W-1:0]  cell_out_q;
	logic               run_done_q;

	logic               cmd_fire;
	logic               cmd_inside;
	logic [AW-1:0]      cmd_addr;
	logic               is_edge;
	logic [CELL_W-1:0]  edge_val;
	logic               last_cell;
	logic               cell_done;

	logic               we_a;
	logic               we_b;
	logic               we_nxt;
	logic [AW-1:0]      waddr;
	logic [CELL_W-1:0]  wdata;
	logic [AW-1:0]      raddr;
	logic [CELL_W-1:0]  rdata_a;
	logic [CELL_W-1:0]  rdata_b;
	logic [CELL_W-1:0]  rd_data;
	logic [CELL_W-1:0]  alu_result;
	alu_ctrl_t          alu_ctrl;

	assign cmd.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign cmd_fire  = cmd.valid && cmd.ready;

	assign cmd_inside = (32'(cmd.row) < GRID_SIZE) && (32'(cmd.col) < GRID_SIZE);
	assign cmd_addr   = AW'(32'(cmd.row) * GRID_SIZE + 32'(cmd.col));

	// Boundary: top row hot except its left corner; every other edge cell is cold.
	assign is_edge   = (row_q == '0) || (row_q == LAST_IDX) ||
	                   (col_q == '0) || (col_q == LAST_IDX);
	assign edge_val  = ((row_q == '0) && (col_q != '0)) ? hot_q : '0;
	assign last_cell = (addr_q == LAST_ADDR);
	assign cell_done = is_edge || (step_q == STP_WRITE);

	assign rd_data = cur_b_q ? rdata_b : rdata_a;

	// Memory ports and stencil unit control.
	always_comb begin
		we_a     = 1'b0;
		we_b     = 1'b0;
		we_nxt   = 1'b0;
		waddr    = addr_q;
		wdata    = '0;
		raddr    = addr_q;
		alu_ctrl = '0;
		case (state_q)
			ST_CLEAR: begin
				we_a = 1'b1;
				we_b = 1'b1;
			end
			ST_IDLE: begin
				raddr = cmd_addr;
				waddr = cmd_addr;
				wdata = cmd.cell_in;
				if (cmd_fire && (cmd.operation == OP_WRITE) && cmd_inside) begin
					we_a = !cur_b_q;
					we_b = cur_b_q;
				end
			end
			ST_FORCE: begin
				wdata = edge_val;
				we_a  = is_edge;
				we_b  = is_edge;
			end
			ST_SWEEP: begin
				if (is_edge) begin
					wdata  = edge_val;
					we_nxt = 1'b1;
				end else begin
					wdata = alu_result;
					case (step_q)
						STP_CENTER: raddr = addr_q;
						STP_NORTH: begin
							raddr              = addr_q - ROW_STEP;
							alu_ctrl.ld_center = 1'b1;
						end
						STP_SOUTH: begin
							raddr           = addr_q + ROW_STEP;
							alu_ctrl.add_nb = 1'b1;
						end
						STP_EAST: begin
							raddr           = addr_q + AW'(1);
							alu_ctrl.add_nb = 1'b1;
						end
						STP_WEST: begin
							raddr           = addr_q - AW'(1);
							alu_ctrl.add_nb = 1'b1;
						end
						STP_LAST: alu_ctrl.add_nb = 1'b1;
						STP_MUL: alu_ctrl.mul = 1'b1;
						STP_WRITE: we_nxt = 1'b1;
						default: raddr = addr_q;
					endcase
				end
				// The next grid is the one that is not current.
				we_a = we_nxt && cur_b_q;
				we_b = we_nxt && !cur_b_q;
			end
			default: begin
				raddr = addr_q;
			end
		endcase
	end

	hdj_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_grid_a (
		.clk  (clk),
		.we   (we_a),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_a)
	);

	hdj_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_grid_b (
		.clk  (clk),
		.we   (we_b),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_b)
	);

	hdj_cell_alu u_alu (
		.clk    (clk),
		.ctrl   (alu_ctrl),
		.rd_data(rd_data),
		.gain   (gain_q),
		.result (alu_result)
	);

	// Sequencer, scan counters, configuration and the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			step_q       <= STP_CENTER;
			addr_q       <= '0;
			row_q        <= '0;
			col_q        <= '0;
			sweep_left_q <= '0;
			cur_b_q      <= 1'b0;
			rd_inside_q  <= 1'b0;
			gain_q       <= GAIN_RST;
			hot_q        <= HOT_RST;
			sweeps_q     <= SWEEPS_RST;
			rsp_valid_q  <= 1'b0;
			cell_out_q   <= '0;
			run_done_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
					CFG_HOT: hot_q <= cfg_data[CELL_W-1:0];
					CFG_SWEEPS: sweeps_q <= cfg_data[SWEEP_W-1:0];
					default: gain_q <= gain_q;
				endcase
			end

			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			// The scan counters advance one cell at a time and wrap after the last one.
			if ((state_q == ST_CLEAR) || (state_q == ST_FORCE) ||
			    ((state_q == ST_SWEEP) && cell_done)) begin
				if (last_cell) begin
					addr_q <= '0;
					row_q  <= '0;
					col_q  <= '0;
				end else begin
					addr_q <= addr_q + AW'(1);
					if (col_q == LAST_IDX) begin
						col_q <= '0;
						row_q <= row_q + CW'(1);
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
			end

			case (state_q)
				ST_CLEAR: begin
					if (last_cell) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_fire) begin
						case (cmd.operation)
							OP_RUN: begin
								state_q <= ST_FORCE;
								step_q  <= STP_CENTER;
							end
							OP_READ: begin
								rd_inside_q <= cmd_inside;
								state_q     <= ST_READ;
							end
							default: begin
								rsp_valid_q <= 1'b1;
								cell_out_q  <= '0;
								run_done_q  <= 1'b0;
							end
						endcase
					end
				end
				ST_READ: begin
					rsp_valid_q <= 1'b1;
					cell_out_q  <= rd_inside_q ? rd_data : '0;
					run_done_q  <= 1'b0;
					state_q     <= ST_IDLE;
				end
				ST_FORCE: begin
					if (last_cell) begin
						if (sweeps_q == '0) begin
							rsp_valid_q <= 1'b1;
							cell_out_q  <= '0;
							run_done_q  <= 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							sweep_left_q <= sweeps_q;
							state_q      <= ST_SWEEP;
						end
					end
				end
				ST_SWEEP: begin
					if (cell_done) begin
						step_q <= STP_CENTER;
						if (last_cell) begin
							// End of a sweep: the freshly written grid becomes current.
							cur_b_q      <= !cur_b_q;
							sweep_left_q <= sweep_left_q - SWEEP_W'(1);
							if (sweep_left_q == SWEEP_W'(1)) begin
								rsp_valid_q <= 1'b1;
								cell_out_q  <= '0;
								run_done_q  <= 1'b1;
								state_q     <= ST_IDLE;
							end
						end
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.cell_out = cell_out_q;
	assign rsp.run_done = run_done_q;
endmodule

// ----- bench/heat_diffusion_jacobi_stencil_test.sv -----
module heat_diffusion_jacobi_stencil_test;
	import hdj_pkg::*;

	// Plate edge length. The block runs at its default size; with 6-bit coordinates every
	// address that the fields can carry then lies on the plate.
	localparam int N = GRID_SIZE_DEF;

	// The unused operation code has no name in the package.
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	// The longest quiet stretch of a correct run is one run item with two sweeps. The limit
	// allows several times that before the run is called hung.
	localparam int QUIET_LIMIT = 400000;

	// Extra cycles after the last result, so that a stray result still gets seen.
	localparam int SETTLE_CYCLES = 50;

	typedef struct {
		logic [CELL_W-1:0] cell_val;
		logic              done;
	} answer_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	hdj_cmd_if cmd_ch();
	hdj_rsp_if rsp_ch();

	heat_diffusion_jacobi_stencil #(
		.GRID_SIZE(N)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd_ch),
		.rsp(rsp_ch)
	);

	// Our own copy of the block's state: both ping-pong plates, which one is current, and
	// the three configuration registers as last written.
	bit [CELL_W-1:0]  plate [2][N*N];
	bit               live;
	bit [GAIN_W-1:0]  gain_q;
	bit [CELL_W-1:0]  hot_q;
	bit [SWEEP_W-1:0] sweeps_q;

	// Answers still owed by the block, oldest first.
	answer_t plate_answers[$];
	answer_t got;

	int failures;
	int quiet_cycles;
	int send_idle_pct;
	int rcv_stall_pct;

	always #5 clk = ~clk;

	// Receiver side. With a stall rate of zero the ready line simply stays high.
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
	end

	// Every result is matched against the oldest outstanding answer, field by field.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (plate_answers.size() == 0) begin
				$display("%0t: unexpected result, cell_out %06h run_done %0b", $time,
					rsp_ch.cell_out, rsp_ch.run_done);
				failures++;
			end else begin
				got = plate_answers.pop_front();
				if (rsp_ch.cell_out !== got.cell_val) begin
					$display("%0t: cell_out expected %06h got %06h", $time, got.cell_val,
						rsp_ch.cell_out);
					failures++;
				end
				if (rsp_ch.run_done !== got.done) begin
					$display("%0t: run_done expected %0b got %0b", $time, got.done,
						rsp_ch.run_done);
					failures++;
				end
			end
		end
	end

	// Hang detection: count cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Forces the plate boundary. The loop order matters: the left column clears the
	// top-left corner after the top row set it hot, while the top-right corner is set hot
	// again by the last pass of the top row.
	task automatic pin_edges(input int g);
		for (int j = 0; j < N; j++) begin
			plate[g][j] = hot_q;
			plate[g][(N-1)*N + j] = '0;
			plate[g][j*N] = '0;
			plate[g][j*N + N - 1] = '0;
		end
	endtask

	// One interior cell of the next plate: center plus the gain times the discrete
	// Laplacian. The product is exact and the arithmetic shift floors it toward minus
	// infinity; the sum is then clamped to the cell range.
	function automatic bit [CELL_W-1:0] relax_cell(input int g, input int i, input int j);
		longint center;
		longint nsum;
		longint prod;
		longint moved;
		center = longint'(plate[g][i*N + j]);
		nsum = longint'(plate[g][(i+1)*N + j]) + longint'(plate[g][(i-1)*N + j])
			+ longint'(plate[g][i*N + j + 1]) + longint'(plate[g][i*N + j - 1]);
		prod = (nsum - 4*center) * longint'(gain_q);
		moved = center + (prod >>> FRAC_W);
		if (moved < 0) begin
			moved = 0;
		end
		if (moved > longint'({CELL_W{1'b1}})) begin
			moved = longint'({CELL_W{1'b1}});
		end
		return moved[CELL_W-1:0];
	endfunction

	// A run pins the edges of both plates, then sweeps from the current plate into the
	// other one and swaps, as many times as the sweep register says.
	task automatic run_plate();
		int src;
		int dst;
		pin_edges(0);
		pin_edges(1);
		for (int k = 0; k < int'(sweeps_q); k++) begin
			src = int'(live);
			dst = int'(!live);
			for (int i = 1; i < N - 1; i++) begin
				for (int j = 1; j < N - 1; j++) begin
					plate[dst][i*N + j] = relax_cell(src, i, j);
				end
			end
			pin_edges(dst);
			live = !live;
		end
	endtask

	// Applies one accepted item to our plate copy and records the answer it must give.
	task automatic predict_item(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] r,
			input logic [COORD_W-1:0] c, input logic [CELL_W-1:0] v);
		answer_t a;
		bit on_plate;
		int idx;
		a.cell_val = '0;
		a.done = 1'b0;
		on_plate = (int'(r) < N) && (int'(c) < N);
		idx = int'(r) * N + int'(c);
		case (op)
			OP_WRITE: begin
				if (on_plate) begin
					plate[live][idx] = v;
				end
			end
			OP_RUN: begin
				run_plate();
				a.done = 1'b1;
			end
			OP_READ: begin
				if (on_plate) begin
					a.cell_val = plate[live][idx];
				end
			end
			default: begin
			end
		endcase
		plate_answers.push_back(a);
	endtask

	// Offers one item, possibly after a random idle gap, and holds it until the block
	// takes it. The caller is always at a rising edge when this starts, and it returns
	// at the edge where the item was taken, with valid still high.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] r,
			input logic [COORD_W-1:0] c, input logic [CELL_W-1:0] v);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.row <= r;
		cmd_ch.col <= c;
		cmd_ch.cell_in <= v;
		do @(posedge clk); while (!cmd_ch.ready);
		predict_item(op, r, c, v);
	endtask

	// Drops valid and waits until every owed answer has come back, so the block is idle.
	// At least one edge passes, so that no control line is assigned twice in one step.
	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (plate_answers.size() != 0);
	endtask

	// Writes all three registers one after another. Only called while the block is idle.
	task automatic program_plate(input logic [GAIN_W-1:0] g, input logic [CELL_W-1:0] h,
			input logic [SWEEP_W-1:0] s);
		cfg_we <= 1'b1;
		cfg_index <= CFG_GAIN;
		cfg_data <= CFG_DATA_W'(g);
		@(posedge clk);
		cfg_index <= CFG_HOT;
		cfg_data <= CFG_DATA_W'(h);
		@(posedge clk);
		cfg_index <= CFG_SWEEPS;
		cfg_data <= CFG_DATA_W'(s);
		@(posedge clk);
		cfg_we <= 1'b0;
		gain_q = g;
		hot_q = h;
		sweeps_q = s;
	endtask

	// Reads right after reset prove the clearing pass, then the far corners are written
	// with all ones and with one and read back. The unused operation code must leave the plate
	// alone and answer zero.
	task automatic test_plate_access();
		send_item(OP_READ, '0, '0, '0);
		send_item(OP_READ, COORD_W'(N-1), COORD_W'(N-1), '1);
		send_item(OP_WRITE, '0, COORD_W'(N-1), '1);
		send_item(OP_WRITE, COORD_W'(N-1), '0, CELL_W'(1));
		send_item(OP_READ, '0, COORD_W'(N-1), '0);
		send_item(OP_READ, COORD_W'(N-1), '0, '0);
		send_item(OP_SPARE, COORD_W'(N-1), COORD_W'(N-1), '1);
		send_item(OP_READ, '0, COORD_W'(N-1), '0);
	endtask

	// A run with zero sweeps only pins the boundary, and still reports that it is done.
	// Gain and hot edge both sit at zero here.
	task automatic test_boundary_only();
		wait_idle();
		program_plate('0, '0, '0);
		send_item(OP_RUN, '0, '0, '0);
		send_item(OP_READ, '0, COORD_W'(N-1), '0);
		send_item(OP_READ, COORD_W'(N-1), '0, '0);
	endtask

	// Largest gain and hottest edge over one sweep. A cold cell under the hot row is
	// warmed by its one hot neighbor, while a full-scale cell among cold neighbors and one
	// under the hot row are pushed below zero, so the lower end of the clamp is taken.
	task automatic test_clamping();
		wait_idle();
		program_plate('1, '1, SWEEP_W'(1));
		send_item(OP_WRITE, COORD_W'(1), COORD_W'(1), '0);
		send_item(OP_WRITE, COORD_W'(2), COORD_W'(2), '1);
		send_item(OP_WRITE, COORD_W'(1), COORD_W'(N-2), '1);
		send_item(OP_RUN, '0, '0, '0);
		send_item(OP_READ, COORD_W'(1), COORD_W'(1), '0);
		send_item(OP_READ, COORD_W'(2), COORD_W'(2), '0);
		send_item(OP_READ, COORD_W'(1), COORD_W'(N-2), '0);
		send_item(OP_READ, '0, '0, '0);
		send_item(OP_READ, '0, COORD_W'(1), '0);
	endtask

	// Reset values of gain and edge with two sweeps, so the plates swap twice.
	task automatic test_nominal_sweeps();
		wait_idle();
		program_plate(GAIN_RST, HOT_RST, SWEEP_W'(2));
		send_item(OP_RUN, '0, '0, '0);
		send_item(OP_READ, COORD_W'(1), COORD_W'(1), '0);
		send_item(OP_READ, COORD_W'(2), COORD_W'(1), '0);
	endtask

	// The largest sweep count is only held in its register; no run is started with it.
	// Cell access must work regardless.
	task automatic test_sweep_register_max();
		wait_idle();
		program_plate(GAIN_RST, HOT_RST, '1);
		send_item(OP_WRITE, COORD_W'(N/2), COORD_W'(N/2), 24'hABCDEF);
		send_item(OP_READ, COORD_W'(N/2), COORD_W'(N/2), '0);
	endtask

	// Random traffic under one idling pattern. Most items write and read a small window
	// of cells, so that reads return values that writes and sweeps have shaped; the
	// window moves now and then and may sit on the edges. A few runs per session, with
	// zero to two sweeps, keep the run time bounded. The rest is scattered access and
	// items with the unused operation code.
	task automatic test_random_session(input int items, input int sender_idle,
			input int receiver_stall);
		int runs_left;
		int roll;
		int r0;
		int c0;
		logic [COORD_W-1:0] r;
		logic [COORD_W-1:0] c;
		logic [CELL_W-1:0] val;
		logic [GAIN_W-1:0] g;
		wait_idle();
		case ($urandom_range(3))
			0: g = GAIN_W'($urandom_range(0, 16384));
			1: g = GAIN_RST;
			2: g = GAIN_W'($urandom_range(16385, 32767));
			default: g = GAIN_W'($urandom_range(0, 4096));
		endcase
		program_plate(g, ($urandom_range(1) != 0) ? HOT_RST : CELL_W'($urandom),
			SWEEP_W'($urandom_range(0, 2)));
		send_idle_pct = sender_idle;
		rcv_stall_pct = receiver_stall;
		runs_left = 3;
		r0 = $urandom_range(0, N - 4);
		c0 = $urandom_range(0, N - 4);
		for (int n = 0; n < items; n++) begin
			if ($urandom_range(99) < 8) begin
				r0 = $urandom_range(0, N - 4);
				c0 = $urandom_range(0, N - 4);
			end
			r = COORD_W'(r0 + $urandom_range(0, 3));
			c = COORD_W'(c0 + $urandom_range(0, 3));
			case ($urandom_range(7))
				0: val = '0;
				1: val = '1;
				2: val = hot_q;
				default: val = CELL_W'($urandom);
			endcase
			roll = $urandom_range(99);
			if (roll < 40) begin
				send_item(OP_WRITE, r, c, val);
			end else if (roll < 84) begin
				send_item(OP_READ, r, c, val);
			end else if (roll < 90) begin
				send_item(OP_READ, COORD_W'($urandom), COORD_W'($urandom), val);
			end else if (roll < 94) begin
				send_item(OP_WRITE, COORD_W'($urandom), COORD_W'($urandom), val);
			end else if (roll < 97 || runs_left == 0) begin
				send_item(OP_SPARE, COORD_W'($urandom), COORD_W'($urandom), val);
			end else begin
				runs_left--;
				send_item(OP_RUN, r, c, val);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_GAIN;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.operation = OP_WRITE;
		cmd_ch.row = '0;
		cmd_ch.col = '0;
		cmd_ch.cell_in = '0;
		rsp_ch.ready = 1'b0;
		failures = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		rcv_stall_pct = 0;

		// Reset state of the block: both plates cold, plate A current, registers at their
		// reset values.
		foreach (plate[g, k]) begin
			plate[g][k] = '0;
		end
		live = 1'b0;
		gain_q = GAIN_RST;
		hot_q = HOT_RST;
		sweeps_q = SWEEPS_RST;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The directed part runs without idling on either side.
		test_plate_access();
		test_boundary_only();
		test_clamping();
		test_nominal_sweeps();
		test_sweep_register_max();

		// Random part: no idling, sender gaps, receiver stalls, then both at once.
		test_random_session(100, 0, 0);
		test_random_session(100, 46, 0);
		test_random_session(100, 0, 46);
		test_random_session(100, 18, 18);

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
